>>> hw/rtl/bmf_pkg.sv
// ----------------------------------------------------------------------------
// bmf_pkg: shared types and constants of the 3x3 box mean filter
// Payload structs, register indexes, size limits and the divide-by-9 helper.
// ----------------------------------------------------------------------------
package bmf_pkg;

	localparam int PIX_W        = 8;
	localparam int CFG_WIDTH_W  = 12;
	localparam int CFG_HEIGHT_W = 16;
	localparam int CFG_DATA_W   = 16;
	localparam int ROW_W        = 16;
	localparam int MAX_WIDTH_DEF = 2048;
	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;
	localparam int MIN_SIZE     = 3;
	// Sum of three pixels, and sum of nine pixels.
	localparam int COLSUM_W     = 10;
	localparam int SUM_W        = 12;
	// floor(s / 9) == (s * 7282) >> 16 for every s below 32768.
	localparam int DIV9_MUL_W   = 13;
	localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 13'd7282;
	localparam int DIV9_SHIFT   = 16;
	localparam int DIV9_PROD_W  = SUM_W + DIV9_MUL_W;

	typedef enum logic [0:0] {
		CMD_PIXEL = 1'b0,
		CMD_DRAIN = 1'b1
	} cmd_t;

	typedef enum logic [0:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [PIX_W-1:0] pixel_in;
	} item_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             frame_end;
		logic             run_last;
	} result_t;

	// Decisions taken when an item is accepted, carried with it into stage 1.
	typedef struct packed {
		logic is_drain;
		logic emit;       // the item produces at least one result
		logic interior;   // first result carries a real mean, else zero
		logic at_edge;    // last column: a zero right-border result follows
		logic frame_end;  // final drain item of the frame
	} ctl_t;

	function automatic logic [PIX_W-1:0] div9(input logic [SUM_W-1:0] s);
		logic [DIV9_PROD_W-1:0] prod;
		prod = DIV9_PROD_W'(s) * DIV9_PROD_W'(DIV9_MUL);
		return prod[DIV9_SHIFT +: PIX_W];
	endfunction

endpackage

>>> hw/rtl/bmf_ctrl.sv
// ----------------------------------------------------------------------------
// bmf_ctrl: frame position tracking
// Holds the size registers and the column, row and drain counters, and
// classifies each incoming item before it enters stage 1.
// ----------------------------------------------------------------------------
module bmf_ctrl #(
	parameter int MAX_WIDTH = bmf_pkg::MAX_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  bmf_pkg::cfg_reg_t                      cfg_addr,
	input  logic [bmf_pkg::CFG_DATA_W-1:0]         cfg_wdata,
	input  logic                                   accept,
	input  bmf_pkg::item_t                         item,
	output logic                                   load,
	output bmf_pkg::ctl_t                          ctl,
	output logic [$clog2(MAX_WIDTH)-1:0]           col
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int CMP_W = (WW > bmf_pkg::CFG_WIDTH_W) ? WW : bmf_pkg::CFG_WIDTH_W;
	localparam int RW    = bmf_pkg::ROW_W;

	logic [bmf_pkg::CFG_WIDTH_W-1:0]  width_q;
	logic [bmf_pkg::CFG_HEIGHT_W-1:0] height_q;
	logic [CW-1:0]                    col_q;
	logic [CW-1:0]                    drain_q;
	logic [RW-1:0]                    row_q;

	logic [CMP_W-1:0] width_ext;
	logic [CMP_W-1:0] width_eff;
	logic [CW-1:0]    last_col;
	logic [RW-1:0]    height_eff;
	logic             frame_full;
	logic             drain_final;

	always_comb begin
		width_ext = CMP_W'(width_q);
		if (width_ext < CMP_W'(bmf_pkg::MIN_SIZE)) begin
			width_eff = CMP_W'(bmf_pkg::MIN_SIZE);
		end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
			width_eff = CMP_W'(MAX_WIDTH);
		end else begin
			width_eff = width_ext;
		end
		last_col = CW'(width_eff - CMP_W'(1));
		height_eff = (height_q < RW'(bmf_pkg::MIN_SIZE)) ? RW'(bmf_pkg::MIN_SIZE) : height_q;
		// All rows are in: only drain items make progress now.
		frame_full  = (row_q >= height_eff);
		drain_final = (drain_q == last_col);
	end

	always_comb begin
		ctl = '0;
		if (item.cmd == bmf_pkg::CMD_DRAIN) begin
			load          = frame_full;
			ctl.is_drain  = 1'b1;
			ctl.emit      = 1'b1;
			ctl.frame_end = drain_final;
		end else begin
			load         = !frame_full;
			ctl.emit     = (row_q != '0) && (col_q != '0);
			ctl.interior = (row_q >= RW'(2)) && (col_q >= CW'(2));
			ctl.at_edge  = (col_q == last_col);
		end
	end

	assign col = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bmf_pkg::CFG_WIDTH_W'(bmf_pkg::RESET_WIDTH);
			height_q <= bmf_pkg::CFG_HEIGHT_W'(bmf_pkg::RESET_HEIGHT);
			col_q    <= '0;
			row_q    <= '0;
			drain_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				bmf_pkg::REG_WIDTH:  width_q  <= cfg_wdata[bmf_pkg::CFG_WIDTH_W-1:0];
				bmf_pkg::REG_HEIGHT: height_q <= cfg_wdata[bmf_pkg::CFG_HEIGHT_W-1:0];
				default: ;
			endcase
			// Any size change starts a fresh frame.
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= '0;
		end else if (accept && load) begin
			if (item.cmd == bmf_pkg::CMD_DRAIN) begin
				if (drain_final) begin
					col_q   <= '0;
					row_q   <= '0;
					drain_q <= '0;
				end else begin
					drain_q <= drain_q + CW'(1);
				end
			end else if (col_q == last_col) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

endmodule

>>> hw/rtl/bmf_line_buf.sv
// ----------------------------------------------------------------------------
// bmf_line_buf: two-row line buffer
// One memory word per column holds the pixels of the two previous rows,
// older row in the upper byte. One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bmf_line_buf #(
	parameter int MAX_WIDTH = bmf_pkg::MAX_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0]   rd_addr,
	output logic [2*bmf_pkg::PIX_W-1:0]    rd_data,
	input  logic                           wr_en,
	input  logic [$clog2(MAX_WIDTH)-1:0]   wr_addr,
	input  logic [2*bmf_pkg::PIX_W-1:0]    wr_data
);

	logic [2*bmf_pkg::PIX_W-1:0] mem [MAX_WIDTH];
	logic [2*bmf_pkg::PIX_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> hw/rtl/bmf_datapath.sv
// ----------------------------------------------------------------------------
// bmf_datapath: window, mean and result register
// Stage 1 holds one item with its line buffer word, forms the 3x3 sum from
// the current column and two stored column sums, divides by 9 and hands up
// to two results to the output register.
// ----------------------------------------------------------------------------
module bmf_datapath #(
	parameter int MAX_WIDTH = bmf_pkg::MAX_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           ld,
	input  bmf_pkg::ctl_t                  ctl,
	input  logic [bmf_pkg::PIX_W-1:0]      pixel,
	input  logic [$clog2(MAX_WIDTH)-1:0]   col,
	input  logic [2*bmf_pkg::PIX_W-1:0]    rd_data,
	output logic                           item_ready,
	output logic                           wr_en,
	output logic [$clog2(MAX_WIDTH)-1:0]   wr_addr,
	output logic [2*bmf_pkg::PIX_W-1:0]    wr_data,
	output logic                           result_valid,
	input  logic                           result_ready,
	output bmf_pkg::result_t               result
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int PW = bmf_pkg::PIX_W;
	localparam int SW = bmf_pkg::COLSUM_W;
	localparam int TW = bmf_pkg::SUM_W;

	logic                 valid_s1;
	bmf_pkg::ctl_t        ctl_s1;
	logic [PW-1:0]        pix_s1;
	logic [CW-1:0]        col_s1;
	logic                 phase_q;
	logic [SW-1:0]        colsum_a_q;
	logic [SW-1:0]        colsum_b_q;
	logic                 res_valid_q;
	bmf_pkg::result_t     res_q;

	logic [PW-1:0]        older;
	logic [PW-1:0]        newer;
	logic [SW-1:0]        cur_sum;
	logic [TW-1:0]        total;
	logic [PW-1:0]        mean;
	logic                 out_free;
	logic                 need_second;
	logic                 push;
	logic                 adv;
	bmf_pkg::result_t     res_d;

	always_comb begin
		older   = rd_data[2*PW-1:PW];
		newer   = rd_data[PW-1:0];
		cur_sum = SW'(older) + SW'(newer) + SW'(pix_s1);
		total   = TW'(cur_sum) + TW'(colsum_a_q) + TW'(colsum_b_q);
		mean    = ctl_s1.interior ? bmf_pkg::div9(total) : '0;

		out_free    = !res_valid_q || result_ready;
		// A last-column pixel owes a zero right-border result after its mean.
		need_second = ctl_s1.at_edge && !phase_q;
		push        = valid_s1 && ctl_s1.emit && out_free;
		adv         = valid_s1 && (!ctl_s1.emit || (out_free && !need_second));

		res_d.pixel_out = phase_q ? '0 : mean;
		res_d.frame_end = ctl_s1.frame_end;
		res_d.run_last  = !need_second;
	end

	assign item_ready = !valid_s1 || adv;
	assign wr_en      = adv && !ctl_s1.is_drain;
	assign wr_addr    = col_s1;
	assign wr_data    = {newer, pix_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			phase_q     <= 1'b0;
			res_valid_q <= 1'b0;
			colsum_a_q  <= '0;
			colsum_b_q  <= '0;
		end else begin
			if (ld) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end

			if (adv) begin
				phase_q <= 1'b0;
			end else if (push) begin
				phase_q <= 1'b1;
			end

			if (push) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end

			// The window shifts once per pixel; only column sums are kept.
			if (wr_en) begin
				colsum_b_q <= colsum_a_q;
				colsum_a_q <= cur_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			ctl_s1 <= ctl;
			pix_s1 <= pixel;
			col_s1 <= col;
		end
		if (push) begin
			res_q <= res_d;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

>>> hw/rtl/box_mean_filter_3x3_top.sv
// ----------------------------------------------------------------------------
// box_mean_filter_3x3_top: streaming 3x3 box mean filter
// Pixels enter in raster order on the item channel (cmd = pixel). Each
// pixel from the second row on, from the second column on, yields the
// output one row up and one column left: the truncated mean of nine
// neighbours, or zero on the top row and left column. A last-column pixel
// also yields the zero right-border output. After the last row, one drain
// item per column (cmd = drain) yields the zero bottom row; the final one
// flags frame_end and starts the next frame. Items that do not fit the
// frame position are taken and dropped. run_last marks the last result of
// each item.
// Items are held in stage 1, results then in the single result register.
// One item is taken per clock unless stage 1 stalls; a last-column pixel
// holds it for both results. The line buffer is one memory of MAX_WIDTH
// words. Reset gives 640 x 480 and the start of a frame; writing either
// size register also restarts the frame. When result_ready is low the
// result register holds, stage 1 fills, and item_ready then drops.
// ----------------------------------------------------------------------------
module box_mean_filter_3x3_top #(
	parameter int MAX_WIDTH = bmf_pkg::MAX_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  bmf_pkg::cfg_reg_t              cfg_addr,
	input  logic [bmf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  bmf_pkg::item_t                 item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output bmf_pkg::result_t               result
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic                          accept;
	logic                          load;
	logic                          ld;
	bmf_pkg::ctl_t                 ctl;
	logic [CW-1:0]                 col;
	logic [2*bmf_pkg::PIX_W-1:0]   rd_data;
	logic                          wr_en;
	logic [CW-1:0]                 wr_addr;
	logic [2*bmf_pkg::PIX_W-1:0]   wr_data;

	assign accept = item_valid && item_ready;
	assign ld     = accept && load;

	bmf_ctrl #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.item      (item),
		.load      (load),
		.ctl       (ctl),
		.col       (col)
	);

	bmf_line_buf #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (ld),
		.rd_addr (col),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	bmf_datapath #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ld           (ld),
		.ctl          (ctl),
		.pixel        (item.pixel_in),
		.col          (col),
		.rd_data      (rd_data),
		.item_ready   (item_ready),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
